/* hw/rtl/lwrp_pkg.sv */
package lwrp_pkg;

  // default number of row slots
  localparam int MaxRowsDef = 16;

  localparam int RowCountW = 5;
  localparam int PadW      = 8;
  localparam int CfgDataW  = 8;
  localparam int CfgIdxW   = 1;
  localparam int GlyphW    = 10;
  localparam int DimW      = 16;
  localparam int RndW      = 17;
  localparam int AreaW     = 33;
  localparam int ChosenW   = 4;

  localparam logic [DimW-1:0]    DimMax      = {DimW{1'b1}};
  localparam logic [CfgIdxW-1:0] CfgRowCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPadding  = 1'b1;

  typedef struct packed {
    logic              first_of_run;
    logic              supported;
    logic [GlyphW-1:0] glyph_width;
    logic [GlyphW-1:0] glyph_height;
  } in_item_t;

  typedef struct packed {
    logic [ChosenW-1:0] chosen_row;
    logic               placed;
    logic [DimW-1:0]    atlas_width;
    logic [DimW-1:0]    atlas_height;
    logic [RndW-1:0]    width_rounded;
    logic [RndW-1:0]    height_rounded;
    logic [AreaW-1:0]   rounded_area;
  } out_item_t;

  // packing outcome handed from the row engine to the result pipe
  typedef struct packed {
    logic [ChosenW-1:0] chosen_row;
    logic               placed;
    logic [DimW-1:0]    atlas_width;
    logic [DimW-1:0]    atlas_height;
  } pack_res_t;

  typedef enum logic {
    BkSearch,
    BkUpdate
  } back_state_e;

  // next power of two at or above v, zero stays zero
  function automatic logic [RndW-1:0] round_pow2(input logic [DimW-1:0] v);
    logic [DimW-1:0] x;
    x = v - DimW'(1);
    x = x | (x >> 1);
    x = x | (x >> 2);
    x = x | (x >> 4);
    x = x | (x >> 8);
    if (v == '0) begin
      return '0;
    end
    return {1'b0, x} + RndW'(1);
  endfunction

endpackage

/* hw/rtl/least_width_row_packer.sv */
// an item waits in the front queue, the row engine picks the least-width row for it
// (argmin over the row widths) and does the row and atlas update once the result pipe
// takes the result; no new item is searched before that, and the result stages follow
// reset: row count 1, padding 0, all row widths and heights and the atlas size zero,
// both queues empty
module least_width_row_packer #(
  parameter int MAX_ROWS = lwrp_pkg::MaxRowsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input
  input  logic                            push,
  output logic                            full,
  input  lwrp_pkg::in_item_t              in_item_i,
  // result output
  output logic                            empty,
  input  logic                            pop,
  output lwrp_pkg::out_item_t             out_item_o,
  // register writes
  input  logic                            cfg_we_i,
  input  logic [lwrp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lwrp_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import lwrp_pkg::*;

  logic [RowCountW-1:0] row_count_q;
  logic [PadW-1:0]      padding_q;

  logic      head_valid, head_pop;
  in_item_t  head;
  logic      res_valid, res_ready;
  pack_res_t res;

  // config registers; the user writes them only while idle, the block does not check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountW'(1);
      padding_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRowCount: row_count_q <= cfg_wdata_i[RowCountW-1:0];
        CfgPadding:  padding_q   <= cfg_wdata_i[PadW-1:0];
        default: ;
      endcase
    end
  end

  // front: takes items and queues them for the row engine
  lwrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .head_pop_i  (head_pop)
  );

  // back: run start clearing, least-width row search, row and atlas update
  lwrp_back #(
    .MAX_ROWS(MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_count_i (row_count_q),
    .padding_i   (padding_q),
    .head_valid_i(head_valid),
    .head_i      (head),
    .head_pop_o  (head_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // result pipe: power-of-two rounding, area, output register
  lwrp_result u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_ready_o(res_ready),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

/* hw/rtl/lwrp_front.sv */
module lwrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  lwrp_pkg::in_item_t in_item_i,
  output logic               head_valid_o,
  output lwrp_pkg::in_item_t head_o,
  input  logic               head_pop_i
);
  import lwrp_pkg::*;

  // two-entry queue toward the row engine
  in_item_t   mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       do_push, do_pop;

  assign full         = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push & ~full;
  assign do_pop       = head_pop_i & head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

/* hw/rtl/lwrp_back.sv */
module lwrp_back #(
  parameter int MAX_ROWS = lwrp_pkg::MaxRowsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [lwrp_pkg::RowCountW-1:0]     row_count_i,
  input  logic [lwrp_pkg::PadW-1:0]          padding_i,
  input  logic                               head_valid_i,
  input  lwrp_pkg::in_item_t                 head_i,
  output logic                               head_pop_o,
  output logic                               res_valid_o,
  output lwrp_pkg::pack_res_t                res_o,
  input  logic                               res_ready_i
);
  import lwrp_pkg::*;

  localparam int RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int Leaves = 2 ** RowW;
  localparam int KeyW   = DimW + 1;

  back_state_e state_q, state_d;

  logic [DimW-1:0]   row_w_q [MAX_ROWS];
  logic [GlyphW-1:0] row_h_q [MAX_ROWS];
  logic [DimW-1:0]   tw_q, th_q;

  in_item_t          op_q;
  logic [RowW-1:0]   best_q;
  logic [DimW-1:0]   best_w_q;
  logic [GlyphW-1:0] best_h_q;

  logic [RowCountW-1:0] nrows;

  // argmin tree, unused rows carry a set top key bit
  logic [KeyW-1:0]   leaf_key [Leaves];
  logic [GlyphW-1:0] leaf_h   [Leaves];
  logic [KeyW-1:0]   tk [RowW+1][Leaves];
  logic [RowW-1:0]   ti [RowW+1][Leaves];
  logic [GlyphW-1:0] tht [RowW+1][Leaves];

  logic              search_go, update_go;
  logic [DimW+1:0]   w_sum;
  logic [DimW-1:0]   w_new, tw_new, th_new, h_base;
  logic [DimW:0]     h_sum;
  logic              grow_h;
  logic [DimW-1:0]   th_start;

  always_comb begin
    if (row_count_i == '0) begin
      nrows = RowCountW'(1);
    end else if (int'(row_count_i) > MAX_ROWS) begin
      nrows = RowCountW'(MAX_ROWS);
    end else begin
      nrows = row_count_i;
    end
  end

  for (genvar g = 0; g < Leaves; g++) begin : g_leaf
    if (g < MAX_ROWS) begin : g_row
      assign leaf_key[g] = {(g >= int'(nrows)), row_w_q[g]};
      assign leaf_h[g]   = row_h_q[g];
    end else begin : g_pad
      assign leaf_key[g] = {KeyW{1'b1}};
      assign leaf_h[g]   = '0;
    end
  end

  always_comb begin
    for (int l = 0; l <= RowW; l++) begin
      for (int j = 0; j < Leaves; j++) begin
        tk[l][j]  = '0;
        ti[l][j]  = '0;
        tht[l][j] = '0;
      end
    end
    for (int j = 0; j < Leaves; j++) begin
      tk[0][j]  = leaf_key[j];
      ti[0][j]  = RowW'(j);
      tht[0][j] = leaf_h[j];
    end
    for (int l = 0; l < RowW; l++) begin
      for (int j = 0; j < (Leaves >> (l + 1)); j++) begin
        // lower index wins ties
        if (tk[l][2*j+1] < tk[l][2*j]) begin
          tk[l+1][j]  = tk[l][2*j+1];
          ti[l+1][j]  = ti[l][2*j+1];
          tht[l+1][j] = tht[l][2*j+1];
        end else begin
          tk[l+1][j]  = tk[l][2*j];
          ti[l+1][j]  = ti[l][2*j];
          tht[l+1][j] = tht[l][2*j];
        end
      end
    end
  end

  // placement arithmetic
  always_comb begin
    w_sum  = {2'b00, best_w_q} + (DimW+2)'(op_q.glyph_width) + (DimW+2)'(padding_i);
    w_new  = (w_sum > (DimW+2)'(DimMax)) ? DimMax : w_sum[DimW-1:0];
    grow_h = (op_q.glyph_height > best_h_q);
    h_base = (th_q >= DimW'(best_h_q)) ? (th_q - DimW'(best_h_q)) : '0;
    h_sum  = {1'b0, h_base} + (DimW+1)'(op_q.glyph_height);
    tw_new = tw_q;
    th_new = th_q;
    if (op_q.supported) begin
      tw_new = (w_new > tw_q) ? w_new : tw_q;
      if (grow_h) begin
        th_new = h_sum[DimW] ? DimMax : h_sum[DimW-1:0];
      end
    end
    th_start = DimW'(padding_i) * (DimW'(nrows) + DimW'(1));
  end

  always_comb begin
    state_d     = state_q;
    head_pop_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      BkSearch: begin
        head_pop_o = head_valid_i;
        if (head_valid_i) begin
          state_d = BkUpdate;
        end
      end
      BkUpdate: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = BkSearch;
        end
      end
      default: state_d = BkSearch;
    endcase
  end

  assign search_go = head_pop_o;
  assign update_go = res_valid_o & res_ready_i;

  assign res_o.chosen_row   = op_q.supported ? ChosenW'(best_q) : '0;
  assign res_o.placed       = op_q.supported;
  assign res_o.atlas_width  = tw_new;
  assign res_o.atlas_height = th_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkSearch;
      tw_q    <= '0;
      th_q    <= '0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        row_w_q[i] <= '0;
        row_h_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (search_go && head_i.first_of_run) begin
        // run start clears every row
        tw_q <= DimW'(padding_i);
        th_q <= th_start;
        for (int i = 0; i < MAX_ROWS; i++) begin
          row_w_q[i] <= DimW'(padding_i);
          row_h_q[i] <= '0;
        end
      end
      if (update_go && op_q.supported) begin
        tw_q <= tw_new;
        th_q <= th_new;
        for (int i = 0; i < MAX_ROWS; i++) begin
          if (RowW'(i) == best_q) begin
            row_w_q[i] <= w_new;
            if (grow_h) begin
              row_h_q[i] <= op_q.glyph_height;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (search_go) begin
      op_q <= head_i;
      if (head_i.first_of_run) begin
        best_q   <= '0;
        best_w_q <= DimW'(padding_i);
        best_h_q <= '0;
      end else begin
        best_q   <= ti[RowW][0];
        best_w_q <= tk[RowW][0][DimW-1:0];
        best_h_q <= tht[RowW][0];
      end
    end
  end

endmodule

/* hw/rtl/lwrp_result.sv */
module lwrp_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  lwrp_pkg::pack_res_t res_i,
  output logic                res_ready_o,
  output logic                empty,
  input  logic                pop,
  output lwrp_pkg::out_item_t out_item_o
);
  import lwrp_pkg::*;

  // stage 1: packing result, stage 2: rounded sizes, stage 3: area, output
  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3;
  pack_res_t s1_q;
  pack_res_t s2_q;
  logic [RndW-1:0] wr2_q, hr2_q;
  out_item_t s3_q;

  assign rdy3        = ~v3_q | pop;
  assign rdy2        = ~v2_q | rdy3;
  assign rdy1        = ~v1_q | rdy2;
  assign res_ready_o = rdy1;
  assign empty       = ~v3_q;
  assign out_item_o  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= res_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && res_valid_i) begin
      s1_q <= res_i;
    end
    if (rdy2 && v1_q) begin
      s2_q  <= s1_q;
      wr2_q <= round_pow2(s1_q.atlas_width);
      hr2_q <= round_pow2(s1_q.atlas_height);
    end
    if (rdy3 && v2_q) begin
      s3_q.chosen_row     <= s2_q.chosen_row;
      s3_q.placed         <= s2_q.placed;
      s3_q.atlas_width    <= s2_q.atlas_width;
      s3_q.atlas_height   <= s2_q.atlas_height;
      s3_q.width_rounded  <= wr2_q;
      s3_q.height_rounded <= hr2_q;
      s3_q.rounded_area   <= AreaW'({{(AreaW-RndW){1'b0}}, wr2_q} * {{(AreaW-RndW){1'b0}}, hr2_q});
    end
  end

endmodule

/* sim/tb_least_width_row_packer.sv */
module tb_least_width_row_packer;
  import lwrp_pkg::*;

  localparam int MaxRows = MaxRowsDef;

  // atlas model plus the queue of atlas reports still owed by the block
  class atlas_scoreboard;
    logic [RowCountW-1:0] row_count;
    logic [PadW-1:0]      pad;
    logic [DimW-1:0]      row_w [MaxRows];
    logic [GlyphW-1:0]    row_h [MaxRows];
    logic [DimW-1:0]      atlas_w;
    logic [DimW-1:0]      atlas_h;
    out_item_t            expected_atlas [$];
    int                   mismatches;
    int                   checked;

    function new();
      row_count  = RowCountW'(1);
      pad        = '0;
      atlas_w    = '0;
      atlas_h    = '0;
      mismatches = 0;
      checked    = 0;
      for (int i = 0; i < MaxRows; i++) begin
        row_w[i] = '0;
        row_h[i] = '0;
      end
    endfunction

    function int pending();
      return expected_atlas.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgRowCount) begin
        row_count = data[RowCountW-1:0];
      end else begin
        pad = data[PadW-1:0];
      end
    endfunction

    function logic [RndW-1:0] ceil_pow2(logic [DimW-1:0] v);
      logic [RndW-1:0] p;
      if (v == '0) begin
        return '0;
      end
      p = RndW'(1);
      while (p < RndW'(v)) p = p << 1;
      return p;
    endfunction

    // one accepted glyph: update rows and atlas, queue the report it causes
    function void note_glyph(in_item_t g);
      int unsigned n;
      int unsigned best;
      int unsigned w;
      int unsigned h;
      out_item_t   r;
      if (row_count == 0) begin
        n = 1;
      end else if (row_count > MaxRows) begin
        n = MaxRows;
      end else begin
        n = row_count;
      end
      best = 0;
      if (g.first_of_run) begin
        for (int i = 0; i < MaxRows; i++) begin
          row_w[i] = DimW'(pad);
          row_h[i] = '0;
        end
        atlas_w = DimW'(pad);
        atlas_h = DimW'(pad * (n + 1));
      end
      if (g.supported) begin
        // narrowest row in use, lowest index on ties
        for (int unsigned i = 1; i < n; i++) begin
          if (row_w[i] < row_w[best]) best = i;
        end
        w = row_w[best] + g.glyph_width + pad;
        if (w > 65535) w = 65535;
        row_w[best] = DimW'(w);
        if (w > atlas_w) atlas_w = DimW'(w);
        if (g.glyph_height > row_h[best]) begin
          h = (atlas_h >= row_h[best]) ? atlas_h - row_h[best] : 0;
          h = h + g.glyph_height;
          if (h > 65535) h = 65535;
          atlas_h = DimW'(h);
          row_h[best] = g.glyph_height;
        end
      end
      r.chosen_row     = g.supported ? ChosenW'(best) : '0;
      r.placed         = g.supported;
      r.atlas_width    = atlas_w;
      r.atlas_height   = atlas_h;
      r.width_rounded  = ceil_pow2(atlas_w);
      r.height_rounded = ceil_pow2(atlas_h);
      r.rounded_area   = AreaW'(r.width_rounded) * AreaW'(r.height_rounded);
      expected_atlas.insert(expected_atlas.size(), r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("mismatch: %s", msg);
    endtask

    task cmp_field(string name, logic [AreaW-1:0] got, logic [AreaW-1:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_atlas.size() == 0) begin
        report($sformatf("result %0d not expected: %h", checked, got));
        checked++;
        return;
      end
      want = expected_atlas.pop_front();
      cmp_field("chosen_row", AreaW'(got.chosen_row), AreaW'(want.chosen_row));
      cmp_field("placed", AreaW'(got.placed), AreaW'(want.placed));
      cmp_field("atlas_width", AreaW'(got.atlas_width), AreaW'(want.atlas_width));
      cmp_field("atlas_height", AreaW'(got.atlas_height), AreaW'(want.atlas_height));
      cmp_field("width_rounded", AreaW'(got.width_rounded), AreaW'(want.width_rounded));
      cmp_field("height_rounded", AreaW'(got.height_rounded), AreaW'(want.height_rounded));
      cmp_field("rounded_area", got.rounded_area, want.rounded_area);
      checked++;
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  out_item_t           out_item;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  atlas_scoreboard sb;
  // set per phase: no idling at all on either side
  bit no_gaps;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  least_width_row_packer #(
    .MAX_ROWS(MaxRows)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int gap_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic in_item_t glyph(int first, int sup, int gw, int gh);
    in_item_t g;
    g.first_of_run = 1'(first);
    g.supported    = 1'(sup);
    g.glyph_width  = GlyphW'(gw);
    g.glyph_height = GlyphW'(gh);
    return g;
  endfunction

  // holds push until the item is taken; push stays high when no gap follows
  task automatic send_glyph(input in_item_t g);
    int gap;
    push    <= 1'b1;
    in_item <= g;
    do @(posedge clk_i); while (full);
    sb.note_glyph(g);
    gap = gap_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender holds off until every owed report has been popped
  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // both registers back to back, write enable held high across both writes
  task automatic write_regs(input int rc, input int pd);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgRowCount;
    cfg_wdata <= CfgDataW'(rc);
    @(posedge clk_i);
    sb.set_reg(CfgRowCount, CfgDataW'(rc));
    cfg_idx   <= CfgPadding;
    cfg_wdata <= CfgDataW'(pd);
    @(posedge clk_i);
    sb.set_reg(CfgPadding, CfgDataW'(pd));
    cfg_we <= 1'b0;
  endtask

  // result side: check each popped item, stall pop at random
  initial begin : result_sink
    int stall;
    stall = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_item);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = gap_cycles();
      end
    end
  end

  initial begin : stimulus
    int        sent;
    int        n_items;
    int        kind;
    bit        wide;
    bit        first;
    int        rc;
    int        pd;
    in_item_t  g;
    sb        = new();
    no_gaps   = 1'b0;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CfgRowCount;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no run start yet: packing on the all-zero reset state
    send_glyph(glyph(0, 1, 5, 7));
    send_glyph(glyph(0, 0, 1023, 1023));
    // zero-size atlas, both dimensions round to zero
    send_glyph(glyph(1, 1, 0, 0));
    // exact power of two, then one past it
    send_glyph(glyph(0, 1, 512, 1));
    send_glyph(glyph(0, 1, 1, 64));
    drain_results();

    // all rows, widest padding, largest glyphs; ties go to lowest row
    write_regs(16, 255);
    send_glyph(glyph(1, 1, 1023, 1023));
    send_glyph(glyph(0, 1, 1023, 1023));
    send_glyph(glyph(0, 1, 1023, 1023));
    send_glyph(glyph(0, 1, 1023, 1023));
    send_glyph(glyph(0, 1, 0, 0));
    // run start on an unsupported glyph: cleared state, nothing placed
    send_glyph(glyph(1, 0, 1023, 1023));
    drain_results();

    // row count zero acts as one
    write_regs(0, 0);
    send_glyph(glyph(1, 1, 1, 1));
    send_glyph(glyph(0, 1, 1023, 0));
    drain_results();

    // upper data bits set, row count 31 clamps to the maximum
    write_regs(255, 1);
    send_glyph(glyph(1, 1, 3, 2));
    send_glyph(glyph(0, 1, 3, 3));
    send_glyph(glyph(0, 0, 0, 0));
    drain_results();

    // row count changed inside a run, height total left as it was
    write_regs(3, 128);
    send_glyph(glyph(0, 1, 700, 900));
    send_glyph(glyph(0, 1, 1, 1023));
    send_glyph(glyph(1, 1, 1023, 1023));
    drain_results();

    // random phases, each with its own register setting
    sent = 0;
    while (sent < 1500) begin
      wide = ($urandom_range(9, 0) == 0);
      if (wide) begin
        // long single run of wide glyphs to drive row widths into saturation
        rc      = $urandom_range(2, 1);
        pd      = 255 - $urandom_range(20, 0);
        n_items = $urandom_range(80, 60);
      end else begin
        kind = $urandom_range(5, 0);
        case (kind)
          0: rc = 1;
          1: rc = 16;
          2: rc = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(31, 17);
          default: rc = $urandom_range(16, 1);
        endcase
        // stray bits above the row count field
        rc   = rc | ($urandom_range(7, 0) << RowCountW);
        kind = $urandom_range(3, 0);
        pd   = (kind == 0) ? 0 : (kind == 1) ? 255 : $urandom_range(255, 0);
        n_items = $urandom_range(60, 10);
      end
      write_regs(rc, pd);
      no_gaps = ($urandom_range(4, 0) == 0);
      for (int k = 0; k < n_items; k++) begin
        if (wide) begin
          g = glyph(int'(k == 0), 1, int'($urandom_range(1023, 900)),
                    int'($urandom_range(1023, 0)));
        end else if ($urandom_range(9, 0) == 0) begin
          // noise: any bit pattern at all
          g = in_item_t'($bits(in_item_t)'($urandom));
        end else begin
          // mostly one run per phase, sometimes continuing the previous one
          first = (k == 0) ? ($urandom_range(3, 0) != 0) : ($urandom_range(24, 0) == 0);
          g = glyph(int'(first), int'($urandom_range(9, 0) != 0),
                    ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(1023, 0),
                    ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(1023, 0));
        end
        send_glyph(g);
        sent++;
      end
      drain_results();
    end

    // nothing owed any more; give stray results time to show up
    repeat (12) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb_least_width_row_packer: PASS");
    end else begin
      $display("tb_least_width_row_packer: FAIL");
    end
    $finish;
  end

  // hang guard: far beyond the slowest correct run
  initial begin : watchdog
    #20_000_000;
    $display("tb_least_width_row_packer: FAIL");
    $finish;
  end

endmodule
